/* rtl/mfmtg_pkg.sv */
package mfmtg_pkg;

	// Default geometry
	localparam int TRACK_BYTES_DEF = 6400;
	localparam int SECTORS_DEF     = 16;

	// State widths
	localparam int POS_W = 13;
	localparam int SEC_W = 5;
	localparam int SEG_W = 5;
	localparam int REM_W = 9;

	// Segment numbers with a special role
	localparam logic [SEG_W-1:0] SEG_SECTOR_FIRST = 5'd5;
	localparam logic [SEG_W-1:0] SEG_SECTOR_LAST  = 5'd19;
	localparam logic [SEG_W-1:0] SEG_PAD          = 5'd20;

	// Gap byte, also used for padding
	localparam logic [7:0] GAP_BYTE = 8'h4e;

	// Configuration register indexes
	localparam logic CFG_CYLINDER = 1'b0;
	localparam logic CFG_SIDE     = 1'b1;

	// Where a segment takes its byte from
	typedef enum logic [1:0] {
		KIND_CONST  = 2'd0,
		KIND_CYL    = 2'd1,
		KIND_SIDE   = 2'd2,
		KIND_SECNUM = 2'd3
	} seg_kind_t;

	// Per-segment descriptor of the track layout
	typedef struct packed {
		seg_kind_t        kind;
		logic [7:0]       code;
		logic [REM_W-1:0] len;
	} seg_desc_t;

	function automatic seg_desc_t seg_desc(input logic [SEG_W-1:0] seg);
		seg_desc_t d;
		d = '{kind: KIND_CONST, code: GAP_BYTE, len: '0};
		case (seg)
			5'd0:  d = '{kind: KIND_CONST,  code: 8'h4e, len: 9'd80};
			5'd1:  d = '{kind: KIND_CONST,  code: 8'h00, len: 9'd12};
			5'd2:  d = '{kind: KIND_CONST,  code: 8'hf6, len: 9'd3};
			5'd3:  d = '{kind: KIND_CONST,  code: 8'hfc, len: 9'd1};
			5'd4:  d = '{kind: KIND_CONST,  code: 8'h4e, len: 9'd50};
			5'd5:  d = '{kind: KIND_CONST,  code: 8'h00, len: 9'd12};
			5'd6:  d = '{kind: KIND_CONST,  code: 8'hf5, len: 9'd3};
			5'd7:  d = '{kind: KIND_CONST,  code: 8'hfe, len: 9'd1};
			5'd8:  d = '{kind: KIND_CYL,    code: 8'h00, len: 9'd1};
			5'd9:  d = '{kind: KIND_SIDE,   code: 8'h00, len: 9'd1};
			5'd10: d = '{kind: KIND_SECNUM, code: 8'h00, len: 9'd1};
			5'd11: d = '{kind: KIND_CONST,  code: 8'h01, len: 9'd1};
			5'd12: d = '{kind: KIND_CONST,  code: 8'hf7, len: 9'd1};
			5'd13: d = '{kind: KIND_CONST,  code: 8'h4e, len: 9'd22};
			5'd14: d = '{kind: KIND_CONST,  code: 8'h00, len: 9'd12};
			5'd15: d = '{kind: KIND_CONST,  code: 8'hf5, len: 9'd3};
			5'd16: d = '{kind: KIND_CONST,  code: 8'hfb, len: 9'd1};
			5'd17: d = '{kind: KIND_CONST,  code: 8'h1a, len: 9'd256};
			5'd18: d = '{kind: KIND_CONST,  code: 8'hf7, len: 9'd1};
			5'd19: d = '{kind: KIND_CONST,  code: 8'h4e, len: 9'd54};
			default: d = '{kind: KIND_CONST, code: GAP_BYTE, len: '0};
		endcase
		return d;
	endfunction

endpackage

/* rtl/mfmtg_seq.sv */
module mfmtg_seq #(
	parameter int TRACK_BYTES = mfmtg_pkg::TRACK_BYTES_DEF,
	parameter int SECTORS     = mfmtg_pkg::SECTORS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       restart,
	input  logic [7:0] cylinder_number,
	input  logic       head_side,
	output logic [7:0] code,
	output logic       last
);

	logic [mfmtg_pkg::POS_W-1:0] pos_q, pos_e, pos_d;
	logic [mfmtg_pkg::SEC_W-1:0] sec_q, sec_e, sec_d;
	logic [mfmtg_pkg::SEG_W-1:0] seg_q, seg_e, seg_d;
	logic [mfmtg_pkg::REM_W-1:0] rem_q, rem_e, rem_d;
	mfmtg_pkg::seg_desc_t        desc;
	mfmtg_pkg::seg_desc_t        first_desc;
	mfmtg_pkg::seg_desc_t        next_desc;

	assign first_desc = mfmtg_pkg::seg_desc('0);

	// Position this item works on: restart goes back to byte zero
	always_comb begin
		if (restart) begin
			pos_e = '0;
			sec_e = '0;
			seg_e = '0;
			rem_e = first_desc.len;
		end else begin
			pos_e = pos_q;
			sec_e = sec_q;
			seg_e = seg_q;
			rem_e = rem_q;
		end
	end

	// Code byte for this position
	assign desc = mfmtg_pkg::seg_desc(seg_e);
	always_comb begin
		if (seg_e >= mfmtg_pkg::SEG_PAD) begin
			code = mfmtg_pkg::GAP_BYTE;
		end else begin
			case (desc.kind)
				mfmtg_pkg::KIND_CYL:    code = cylinder_number;
				mfmtg_pkg::KIND_SIDE:   code = {7'd0, head_side};
				mfmtg_pkg::KIND_SECNUM: code = 8'(sec_e) + 8'd1;
				default:                code = desc.code;
			endcase
		end
	end

	assign last = (pos_e >= mfmtg_pkg::POS_W'(TRACK_BYTES - 1));

	// Advance to the next position
	assign next_desc = mfmtg_pkg::seg_desc(seg_e + 5'd1);
	always_comb begin
		pos_d = pos_e + 1'b1;
		sec_d = sec_e;
		seg_d = seg_e;
		rem_d = rem_e;
		if (last) begin
			pos_d = '0;
			sec_d = '0;
			seg_d = '0;
			rem_d = first_desc.len;
		end else if (seg_e >= mfmtg_pkg::SEG_PAD) begin
			seg_d = mfmtg_pkg::SEG_PAD;
			rem_d = '0;
		end else if (rem_e > 9'd1) begin
			rem_d = rem_e - 1'b1;
		end else if (seg_e == mfmtg_pkg::SEG_SECTOR_LAST) begin
			if (sec_e < mfmtg_pkg::SEC_W'(SECTORS - 1)) begin
				sec_d = sec_e + 1'b1;
				seg_d = mfmtg_pkg::SEG_SECTOR_FIRST;
				rem_d = mfmtg_pkg::seg_desc(mfmtg_pkg::SEG_SECTOR_FIRST).len;
			end else begin
				seg_d = mfmtg_pkg::SEG_PAD;
				rem_d = '0;
			end
		end else begin
			seg_d = seg_e + 1'b1;
			rem_d = next_desc.len;
		end
	end

	// Track position state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sec_q <= '0;
			seg_q <= '0;
			rem_q <= first_desc.len;
		end else if (step) begin
			pos_q <= pos_d;
			sec_q <= sec_d;
			seg_q <= seg_d;
			rem_q <= rem_d;
		end
	end

endmodule

/* rtl/mfm_format_track_image_generator_top.sv */
// Write-track image generator for double-density floppy formatting.
// Each item taken on the s_ channel requests one byte of the track image;
// s_tdata[0] = restart, which sends the generator back to byte zero first.
// The m_ channel returns one item per request: m_tdata is the inverted
// controller code byte, m_tlast marks the final byte of the track, after
// which the next request starts a new track.
// Cylinder and head values for the sector ID fields are written through
// cfg_we/cfg_index/cfg_data (index 0 cylinder, index 1 head); the user must
// write them only while idle, which the block itself does not enforce.
// Throughput: one byte per cycle while the receiver takes every result;
// the position counters advance once per item and the byte is picked from
// a small constant layout table. A single output register holds the
// result; while the receiver stalls with a result pending, s_tready drops
// and the counters hold. Reset clears the output valid flag, sets the
// counters to track byte zero and clears cylinder and head to zero.
module mfm_format_track_image_generator_top #(
	parameter int TRACK_BYTES = mfmtg_pkg::TRACK_BYTES_DEF,
	parameter int SECTORS     = mfmtg_pkg::SECTORS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [0] restart, [7:1] zero
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] track_byte
	output logic       m_tlast,   // last_byte
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);

	logic [7:0] cylinder_q;
	logic       side_q;
	logic       step;
	logic [7:0] code;
	logic       last;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cylinder_q <= '0;
			side_q     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				mfmtg_pkg::CFG_CYLINDER: cylinder_q <= cfg_data;
				mfmtg_pkg::CFG_SIDE:     side_q     <= cfg_data[0];
				default:                 side_q     <= side_q;
			endcase
		end
	end

	assign s_tready = !out_valid_q || m_tready;
	assign step     = s_tvalid && s_tready;

	mfmtg_seq #(
		.TRACK_BYTES (TRACK_BYTES),
		.SECTORS     (SECTORS)
	) u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (step),
		.restart         (s_tdata[0]),
		.cylinder_number (cylinder_q),
		.head_side       (side_q),
		.code            (code),
		.last            (last)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_byte_q <= ~code;
			out_last_q <= last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;

endmodule

/* dv/tb.sv */
module tb;

	localparam int TRACK_LEN    = 6400;
	localparam int SECTOR_COUNT = 16;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int HOLD_CYCLES  = 300;

	// Track layout as seen by the checker: byte source, code and run length per segment
	localparam mfmtg_pkg::seg_kind_t LAYOUT_KIND [20] = '{
		mfmtg_pkg::KIND_CONST, mfmtg_pkg::KIND_CONST, mfmtg_pkg::KIND_CONST,
		mfmtg_pkg::KIND_CONST, mfmtg_pkg::KIND_CONST,
		mfmtg_pkg::KIND_CONST, mfmtg_pkg::KIND_CONST, mfmtg_pkg::KIND_CONST,
		mfmtg_pkg::KIND_CYL, mfmtg_pkg::KIND_SIDE,
		mfmtg_pkg::KIND_SECNUM, mfmtg_pkg::KIND_CONST, mfmtg_pkg::KIND_CONST,
		mfmtg_pkg::KIND_CONST, mfmtg_pkg::KIND_CONST,
		mfmtg_pkg::KIND_CONST, mfmtg_pkg::KIND_CONST, mfmtg_pkg::KIND_CONST,
		mfmtg_pkg::KIND_CONST, mfmtg_pkg::KIND_CONST
	};
	localparam logic [7:0] LAYOUT_CODE [20] = '{
		8'h4e, 8'h00, 8'hf6, 8'hfc, 8'h4e,
		8'h00, 8'hf5, 8'hfe, 8'h00, 8'h00,
		8'h00, 8'h01, 8'hf7, 8'h4e, 8'h00,
		8'hf5, 8'hfb, 8'h1a, 8'hf7, 8'h4e
	};
	localparam int LAYOUT_LEN [20] = '{
		80, 12, 3, 1, 50,
		12, 3, 1, 1, 1,
		1, 1, 1, 22, 12,
		3, 1, 256, 1, 54
	};

	typedef struct packed {
		logic [7:0] track_byte;
		logic       last_byte;
	} track_result_t;

	// Tracks the write-track position and holds the bytes still owed by the block
	class track_board;
		logic [mfmtg_pkg::POS_W-1:0] pos;
		logic [mfmtg_pkg::SEC_W-1:0] sector;
		logic [mfmtg_pkg::SEG_W-1:0] seg;
		logic [mfmtg_pkg::REM_W-1:0] remaining;
		logic [7:0]                  cylinder;
		logic                        side;
		track_result_t               want_q[$];
		int                          errors;

		function new();
			cylinder = '0;
			side = 1'b0;
			errors = 0;
			rewind();
		endfunction

		function void rewind();
			pos = '0;
			sector = '0;
			seg = '0;
			remaining = mfmtg_pkg::REM_W'(LAYOUT_LEN[0]);
		endfunction

		function void write_reg(logic idx, logic [7:0] value);
			if (idx == mfmtg_pkg::CFG_CYLINDER)
				cylinder = value;
			else
				side = value[0];
		endfunction

		function int pending();
			return want_q.size();
		endfunction

		function void step_position();
			if (int'(pos) + 1 >= TRACK_LEN) begin
				rewind();
				return;
			end
			pos = pos + 1'b1;
			if (seg >= mfmtg_pkg::SEG_PAD) begin
				seg = mfmtg_pkg::SEG_PAD;
				remaining = '0;
				return;
			end
			if (remaining > 1) begin
				remaining = remaining - 1'b1;
				return;
			end
			if (seg == mfmtg_pkg::SEG_SECTOR_LAST) begin
				if (int'(sector) + 1 < SECTOR_COUNT) begin
					sector = sector + 1'b1;
					seg = mfmtg_pkg::SEG_SECTOR_FIRST;
					remaining = mfmtg_pkg::REM_W'(LAYOUT_LEN[mfmtg_pkg::SEG_SECTOR_FIRST]);
				end else begin
					seg = mfmtg_pkg::SEG_PAD;
					remaining = '0;
				end
				return;
			end
			seg = seg + 1'b1;
			remaining = mfmtg_pkg::REM_W'(LAYOUT_LEN[seg]);
		endfunction

		// One accepted request: pick the byte at the current position, then move on
		function void note_request(logic restart);
			logic [7:0]    code;
			track_result_t want;
			if (restart)
				rewind();
			if (seg >= mfmtg_pkg::SEG_PAD) begin
				code = mfmtg_pkg::GAP_BYTE;
			end else begin
				case (LAYOUT_KIND[seg])
					mfmtg_pkg::KIND_CYL:    code = cylinder;
					mfmtg_pkg::KIND_SIDE:   code = {7'b0, side};
					mfmtg_pkg::KIND_SECNUM: code = 8'(sector) + 8'd1;
					default:                code = LAYOUT_CODE[seg];
				endcase
			end
			want.track_byte = ~code;
			want.last_byte = (int'(pos) + 1 >= TRACK_LEN);
			want_q.push_back(want);
			step_position();
		endfunction

		function void check_result(logic [7:0] data, logic last);
			track_result_t want;
			if (want_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected item: track_byte %h last_byte %b",
					$time, data, last);
				return;
			end
			want = want_q.pop_front();
			if (data !== want.track_byte) begin
				errors++;
				$display("%0t: track_byte mismatch: expected %h actual %h",
					$time, want.track_byte, data);
			end
			if (last !== want.last_byte) begin
				errors++;
				$display("%0t: last_byte mismatch: expected %b actual %b",
					$time, want.last_byte, last);
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;   // [0] restart, [7:1] zero
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;   // [7:0] track_byte
	logic       m_tlast;   // last_byte
	logic       cfg_we;
	logic       cfg_index;
	logic [7:0] cfg_data;

	track_board board;
	bit         calm;
	bit         hold_off;
	int         cycle_count;

	mfm_format_track_image_generator_top #(
		.TRACK_BYTES(TRACK_LEN),
		.SECTORS    (SECTOR_COUNT)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run limit
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Watch both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				board.note_request(s_tdata[0]);
			if (m_tvalid && m_tready)
				board.check_result(m_tdata, m_tlast);
		end
	end

	// Receiver: random stalls, one long hold on request, none at the end
	initial begin
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off = 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	task automatic send_request(input bit restart);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'b0, restart};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Stop offering and wait for every owed byte
	task automatic wait_track_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(input logic [7:0] cyl, input logic [7:0] side_word);
		cfg_we <= 1'b1;
		cfg_index <= mfmtg_pkg::CFG_CYLINDER;
		cfg_data <= cyl;
		@(posedge clk);
		cfg_index <= mfmtg_pkg::CFG_SIDE;
		cfg_data <= side_word;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.write_reg(mfmtg_pkg::CFG_CYLINDER, cyl);
		board.write_reg(mfmtg_pkg::CFG_SIDE, side_word);
	endtask

	// A fresh track followed by a stretch of plain requests, with a rare stray restart
	task automatic run_track(input int count);
		send_request(1'b1);
		repeat (count - 1)
			send_request($urandom_range(0, 199) == 0);
	endtask

	initial begin
		int issued;
		int run_len;
		board = new();
		calm = 1'b0;
		hold_off = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = mfmtg_pkg::CFG_CYLINDER;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset values, restart at byte zero, back-to-back restarts, restart mid-gap
		repeat (3) send_request(1'b0);
		send_request(1'b1);
		send_request(1'b1);
		repeat (6) send_request(1'b0);
		send_request(1'b1);
		repeat (4) send_request(1'b0);
		send_request(1'b1);
		repeat (3) send_request(1'b0);
		wait_track_idle();

		// Extreme ID values over a whole track, through padding, last byte and wrap
		set_config(8'hff, 8'hff);
		send_request(1'b1);
		hold_off = 1'b1;
		repeat (40) send_request(1'b0);
		repeat (TRACK_LEN + 200) send_request(1'b0);
		wait_track_idle();

		// Low extremes, random runs of varying depth
		set_config(8'h00, {7'($urandom_range(0, 127)), 1'b0});
		issued = 0;
		while (issued < 1700) begin
			run_len = $urandom_range(0, 4) == 0 ?
				$urandom_range(1, 40) : $urandom_range(150, 900);
			run_track(run_len);
			issued += run_len;
		end
		wait_track_idle();

		// Random IDs, no idling on either side
		calm = 1'b1;
		set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		run_track(400);
		wait_track_idle();

		if (board.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* filelist.f */
rtl/mfmtg_pkg.sv
rtl/mfmtg_seq.sv
rtl/mfm_format_track_image_generator_top.sv
dv/tb.sv
